// ----- design/cbf_pkg.sv -----
// shared constants, codes and types of the channel block filter
package cbf_pkg;

    // table and packet sizing
    localparam int CHANNEL_BITS     = 16;
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int PKT_W            = $clog2(MAX_PACKET_BYTES);
    localparam int PKT_MAX          = MAX_PACKET_BYTES - 1;
    localparam int TABLE_DEPTH      = 1 << CHANNEL_BITS;

    // fixed field widths
    localparam int LEN_W      = 11;
    localparam int COUNT_W    = 11;
    localparam int RATE_W     = 12;
    localparam int SIZE_W     = 4;
    localparam int TCH_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // result queue sizing
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLE_SIZE = 2'd1;
    localparam logic [RATE_W-1:0]    MAX_RATE_RESET      = 12'd500;
    localparam logic [SIZE_W-1:0]    MAX_SIZE_RESET      = 4'd4;

    // item and result codes
    localparam logic MODE_DATA    = 1'b0;
    localparam logic MODE_TABLE   = 1'b1;
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // number of data results carried by one group
    localparam logic [2:0] NDATA_NONE   = 3'd0;
    localparam logic [2:0] NDATA_BYTE   = 3'd1;
    localparam logic [2:0] NDATA_HEADER = 3'd4;

    // all results caused by one input item
    typedef struct packed {
        logic [2:0]         n_data;
        logic [31:0]        word;
        logic               summary;
        logic [COUNT_W-1:0] count;
        logic               aborted;
    } t_group;

endpackage

// ----- design/cbf_ram.sv -----
// generic simple dual-port ram with registered read
module cbf_ram #(
    parameter int  WIDTH = 1,
    parameter int  DEPTH = 65536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cbf_rq.sv -----
// result queue: holds result groups and hands them out one beat at a time
module cbf_rq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  cbf_pkg::t_group         i_group,
    output logic                    o_full,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_kind,
    output logic [7:0]              o_byte,
    output logic [cbf_pkg::COUNT_W-1:0] o_count,
    output logic                    o_aborted,
    output logic                    o_last
);
    import cbf_pkg::*;

    t_group          r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic [1:0]      r_sub;

    t_group     c_head;
    logic [2:0] c_total;
    logic       c_is_data;
    logic       c_beat;
    logic       c_pop;

    // head group decode
    assign c_head    = r_q[r_rp];
    assign c_total   = c_head.n_data + {2'b00, c_head.summary};
    assign c_is_data = {1'b0, r_sub} < c_head.n_data;

    assign o_valid   = r_cnt != '0;
    assign o_full    = r_cnt == (Q_AW + 1)'(Q_DEPTH);
    assign o_last    = {1'b0, r_sub} == (c_total - 3'd1);
    assign c_beat    = o_valid && !i_stall;
    assign c_pop     = c_beat && o_last;

    // result fields of the current beat
    always_comb begin
        o_kind    = c_is_data ? KIND_DATA : KIND_SUMMARY;
        o_count   = c_is_data ? '0 : c_head.count;
        o_aborted = c_is_data ? 1'b0 : c_head.aborted;
        o_byte    = '0;
        if (c_is_data) begin
            case (r_sub)
                2'd0:    o_byte = c_head.word[31:24];
                2'd1:    o_byte = c_head.word[23:16];
                2'd2:    o_byte = c_head.word[15:8];
                2'd3:    o_byte = c_head.word[7:0];
                default: o_byte = '0;
            endcase
        end
    end

    // group storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_group;
        end
    end

    // pointers, fill level and beat index within the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sub <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (c_pop) begin
                r_rp  <= r_rp + 1'b1;
                r_sub <= '0;
            end else if (c_beat) begin
                r_sub <= r_sub + 1'b1;
            end
            case ({i_push, c_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || c_pop))
        else $error("result queue written while full");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW + 1)'(Q_DEPTH))
        else $error("result queue level out of range");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (c_total != 3'd0 && {1'b0, r_sub} < c_total))
        else $error("head group empty or beat index past its end");

    a_sub_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> r_sub == 2'd0)
        else $error("beat index moved with no group queued");

endmodule

// ----- design/channel_block_filter.sv -----
// top level of the channel block filter: block walk, channel table and ports
//
// Input channel (i_in_valid / o_in_stall) carries one item per beat: either one
// byte of a packet's channel block section (mode data) or a channel table write
// (mode table). Output channel (o_out_valid / i_out_stall) carries one result
// per beat: a copied byte of an enabled block or an end-of-packet summary with
// the copied byte count and the abort flag; o_last marks the final result of
// the input item that caused it. The configuration port (i_cfg_valid /
// o_cfg_ready) writes the largest legal sample rate and sample size code.
// An item's results are registered in the group queue before they are output.
// One item is taken per cycle while o_in_stall is low; a header's fourth byte
// releases four results at once, which a group queue of eight entries absorbs
// while it drains at one beat per cycle unless the receiver stalls. The channel
// table is a 64K x 1 ram read once per header, on its second byte. After reset
// the table is filled with ones, one entry per cycle; o_in_stall stays high
// during that pass, configuration writes are taken throughout. When the receiver
// stalls, results wait in the queue and the input stalls only once it is full.
module channel_block_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first_of_packet,
    input  logic [cbf_pkg::LEN_W-1:0]     i_packet_length,
    input  logic [cbf_pkg::TCH_W-1:0]     i_table_channel,
    input  logic                          i_table_enable,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [7:0]                    o_out_byte,
    output logic [cbf_pkg::COUNT_W-1:0]   o_copied_count,
    output logic                          o_aborted,
    output logic                          o_last,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cbf_pkg::*;

    localparam int GS_W = SIZE_W + RATE_W + 1;

    // walk state
    logic [PKT_W-1:0]   r_pkt_left;
    logic [31:0]        r_hdr;
    logic [1:0]         r_hdr_seen;
    logic [PKT_W-1:0]   r_blk_left;
    logic               r_passes;
    logic               r_aborted;
    logic [COUNT_W-1:0] r_copied;
    logic [RATE_W-1:0]  r_max_rate;
    logic [SIZE_W-1:0]  r_max_size;

    // table lookup and clearing pass
    logic                    r_clearing;
    logic [CHANNEL_BITS-1:0] r_clr_addr;
    logic                    r_rd_pend;
    logic [CHANNEL_BITS-1:0] r_chan;
    logic                    r_chan_en;

    logic [PKT_W-1:0]   n_pkt_left;
    logic [31:0]        n_hdr;
    logic [1:0]         n_hdr_seen;
    logic [PKT_W-1:0]   n_blk_left;
    logic               n_passes;
    logic               n_aborted;
    logic [COUNT_W-1:0] n_copied;
    logic               n_chan_en;

    logic                    c_in_acc;
    logic                    c_data_acc;
    logic                    c_tbl_acc;
    logic                    q_full;
    logic [PKT_W-1:0]        c_plen_sat;
    logic [PKT_W-1:0]        c_pl_start;
    logic [PKT_W-1:0]        c_pl_dec;
    logic [31:0]             c_hdr_new;
    logic [SIZE_W-1:0]       c_ss;
    logic [RATE_W-1:0]       c_sr;
    logic [15:0]             c_prod;
    logic [GS_W-1:0]         c_gs4;
    logic                    c_bad;
    logic                    c_rd_issue;
    logic [15:0]             c_rd_ch;
    logic [CHANNEL_BITS-1:0] c_rd_addr;
    logic [CHANNEL_BITS-1:0] c_tbl_addr;
    logic                    c_tbl_hit;
    logic                    c_push;
    t_group                  c_grp;
    logic                    ram_we;
    logic [CHANNEL_BITS-1:0] ram_waddr;
    logic [0:0]              ram_wdata;
    logic [0:0]              ram_rdata;

    // handshakes
    assign o_in_stall  = r_clearing || q_full;
    assign o_cfg_ready = 1'b1;
    assign c_in_acc    = i_in_valid && !o_in_stall;
    assign c_data_acc  = c_in_acc && (i_mode == MODE_DATA);
    assign c_tbl_acc   = c_in_acc && (i_mode == MODE_TABLE);

    // packet length clamp
    always_comb begin
        if (i_packet_length == '0) begin
            c_plen_sat = PKT_W'(1);
        end else if (32'(i_packet_length) > PKT_MAX) begin
            c_plen_sat = PKT_W'(PKT_MAX);
        end else begin
            c_plen_sat = PKT_W'(i_packet_length);
        end
    end

    assign c_pl_start = i_first_of_packet ? c_plen_sat : r_pkt_left;
    assign c_pl_dec   = c_pl_start - 1'b1;

    // header decode and rate, size and block size checks on the fourth header byte
    assign c_hdr_new = {r_hdr[23:0], i_data_byte};
    assign c_ss      = c_hdr_new[15:12];
    assign c_sr      = c_hdr_new[11:0];
    assign c_prod    = 16'(c_ss) * 16'(c_sr - 12'd1);
    assign c_gs4     = (c_ss == '0) ? (GS_W'(c_sr[RATE_W-1:1]) + GS_W'(4))
                                    : (GS_W'(c_prod) + GS_W'(4));
    assign c_bad     = (c_sr > r_max_rate) || (c_ss > r_max_size) ||
                       (c_ss != '0 && c_sr == '0) || (c_gs4 > GS_W'(c_pl_dec));

    // table read address taken from the first two header bytes
    assign c_rd_ch   = {r_hdr[7:0], i_data_byte};
    assign c_rd_addr = c_rd_ch[CHANNEL_BITS-1:0];

    // block walk for one data byte
    always_comb begin
        n_pkt_left = r_pkt_left;
        n_hdr      = r_hdr;
        n_hdr_seen = r_hdr_seen;
        n_blk_left = r_blk_left;
        n_passes   = r_passes;
        n_aborted  = r_aborted;
        n_copied   = r_copied;
        c_grp      = '0;
        c_rd_issue = 1'b0;
        if (c_data_acc) begin
            if (i_first_of_packet) begin
                n_pkt_left = c_plen_sat;
                n_hdr      = '0;
                n_hdr_seen = '0;
                n_blk_left = '0;
                n_passes   = 1'b0;
                n_aborted  = 1'b0;
                n_copied   = '0;
            end
            if (n_pkt_left != '0) begin
                n_pkt_left = n_pkt_left - 1'b1;
                if (!n_aborted) begin
                    if (n_blk_left == '0) begin
                        n_hdr = c_hdr_new;
                        if (n_hdr_seen == 2'd1) begin
                            c_rd_issue = 1'b1;
                        end
                        if (n_hdr_seen == 2'd3) begin
                            n_hdr_seen = '0;
                            if (c_bad) begin
                                n_aborted = 1'b1;
                            end else begin
                                n_blk_left = c_gs4[PKT_W-1:0];
                                n_passes   = r_chan_en;
                                if (r_chan_en) begin
                                    c_grp.n_data = NDATA_HEADER;
                                    c_grp.word   = c_hdr_new;
                                    n_copied     = n_copied + COUNT_W'(4);
                                end
                            end
                        end else begin
                            n_hdr_seen = n_hdr_seen + 1'b1;
                            if (n_pkt_left == '0) begin
                                n_aborted = 1'b1;
                            end
                        end
                    end else begin
                        n_blk_left = n_blk_left - 1'b1;
                        if (n_passes) begin
                            c_grp.n_data = NDATA_BYTE;
                            c_grp.word   = {i_data_byte, 24'd0};
                            n_copied     = n_copied + 1'b1;
                        end
                    end
                end
                // packet end summary
                if (n_pkt_left == '0) begin
                    c_grp.summary = 1'b1;
                    c_grp.count   = n_copied;
                    c_grp.aborted = n_aborted;
                end
            end
        end
    end

    assign c_push = (c_grp.n_data != NDATA_NONE) || c_grp.summary;

    // channel enable of the current header, with table writes forwarded
    assign c_tbl_addr = i_table_channel[CHANNEL_BITS-1:0];
    assign c_tbl_hit  = c_tbl_acc && (c_tbl_addr == r_chan);

    always_comb begin
        n_chan_en = r_chan_en;
        if (c_tbl_hit) begin
            n_chan_en = i_table_enable;
        end else if (r_rd_pend) begin
            n_chan_en = ram_rdata[0];
        end
    end

    // table ram write port: clearing pass or table write item
    assign ram_we       = r_clearing || c_tbl_acc;
    assign ram_waddr    = r_clearing ? r_clr_addr : c_tbl_addr;
    assign ram_wdata[0] = r_clearing ? 1'b1 : i_table_enable;

    cbf_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (c_rd_addr),
        .o_rdata (ram_rdata)
    );

    // control and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_left <= '0;
            r_hdr      <= '0;
            r_hdr_seen <= '0;
            r_blk_left <= '0;
            r_passes   <= 1'b0;
            r_aborted  <= 1'b0;
            r_copied   <= '0;
            r_max_rate <= MAX_RATE_RESET;
            r_max_size <= MAX_SIZE_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_rd_pend  <= 1'b0;
        end else begin
            r_pkt_left <= n_pkt_left;
            r_hdr      <= n_hdr;
            r_hdr_seen <= n_hdr_seen;
            r_blk_left <= n_blk_left;
            r_passes   <= n_passes;
            r_aborted  <= n_aborted;
            r_copied   <= n_copied;
            r_rd_pend  <= c_rd_issue;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_SAMPLE_RATE: r_max_rate <= i_cfg_data[RATE_W-1:0];
                    REG_MAX_SAMPLE_SIZE: r_max_size <= i_cfg_data[SIZE_W-1:0];
                    default:             r_max_rate <= r_max_rate;
                endcase
            end
        end
    end

    // lookup registers
    always_ff @(posedge i_clk) begin
        if (c_rd_issue) begin
            r_chan <= c_rd_addr;
        end
        r_chan_en <= n_chan_en;
    end

    cbf_rq u_rq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (c_push),
        .i_group   (c_grp),
        .o_full    (q_full),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_kind    (o_kind),
        .o_byte    (o_out_byte),
        .o_count   (o_copied_count),
        .o_aborted (o_aborted),
        .o_last    (o_last)
    );

    a_abort_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aborted |-> r_blk_left == '0)
        else $error("block still open after abort");

    a_block_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_left <= r_pkt_left)
        else $error("block runs past packet end");

    a_header_between_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_seen != 2'd0 |-> r_blk_left == '0)
        else $error("header bytes counted inside a block");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_addr) == '1)
        else $error("clearing pass ended early");

    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !c_rd_issue && !c_push)
        else $error("item processed during clearing pass");

endmodule
